>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising edge, quiet during reset.
`define ASSERT_NOW(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |-> (cons)) \
		else $error("check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising edge, quiet during reset.
`define ASSERT_NEXT(lbl, clk_s, rst_n_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n_s) (ante) |=> (cons)) \
		else $error("check failed: next-cycle implication");

`endif

>>> src/epe_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine plant Euler step package
// Widths, constants, beat types and saturation helpers shared by the core.
// ----------------------------------------------------------------------------
package epe_pkg;

	localparam int EPE_COEF_W  = 32;  // signed Q16.16 coefficients and I/O
	localparam int EPE_RPM_W   = 31;  // unsigned Q15.16 registers and rpm output
	localparam int EPE_S_W     = 48;  // signed Q32.16 states
	localparam int EPE_SUM_W   = 50;  // three-term sum before saturation
	localparam int EPE_TGT_W   = 33;  // temperature target
	localparam int EPE_FRAC    = 16;
	localparam int EPE_DT_DIV  = 100; // dt = 1/100 s
	localparam int EPE_CFG_W   = 3;

	localparam logic signed [EPE_COEF_W-1:0] EPE_ROOM_TEMP       = 32'sd1310720;
	localparam logic signed [EPE_COEF_W-1:0] EPE_OPERATING_DELTA = 32'sd4587520;
	localparam logic signed [EPE_COEF_W-1:0] EPE_REDLINE_DELTA   = 32'sd6553600;

	typedef enum logic [EPE_CFG_W-1:0] {
		CFG_A11     = 3'd0,
		CFG_A12     = 3'd1,
		CFG_A21     = 3'd2,
		CFG_B11     = 3'd3,
		CFG_C12     = 3'd4,
		CFG_IDLE    = 3'd5,
		CFG_REDLINE = 3'd6,
		CFG_INVTAU  = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic signed [EPE_COEF_W-1:0] commanded_rpm;
		logic                         engine_on;
	} in_beat_t;

	typedef struct packed {
		logic [EPE_RPM_W-1:0]         engine_rpm;
		logic signed [EPE_COEF_W-1:0] engine_temperature;
	} out_beat_t;

	typedef struct packed {
		logic                         start;
		logic signed [EPE_COEF_W-1:0] a;
		logic signed [EPE_S_W-1:0]    b;
	} mul_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [EPE_S_W-1:0] p;
	} mul_rsp_t;

	typedef struct packed {
		logic                      start;
		logic signed [EPE_S_W-1:0] v;
	} div_req_t;

	typedef struct packed {
		logic                      done;
		logic signed [EPE_S_W-1:0] q;
	} div_rsp_t;

	function automatic logic signed [EPE_SUM_W-1:0] sext_s(input logic signed [EPE_S_W-1:0] v);
		return {{(EPE_SUM_W-EPE_S_W){v[EPE_S_W-1]}}, v};
	endfunction

	// Saturate a wide sum to a signed state.
	function automatic logic signed [EPE_S_W-1:0] sat_s(input logic signed [EPE_SUM_W-1:0] v);
		logic signed [EPE_S_W-1:0] r;
		if (v[EPE_SUM_W-1:EPE_S_W-1] == '0 || v[EPE_SUM_W-1:EPE_S_W-1] == '1) begin
			r = v[EPE_S_W-1:0];
		end else if (v[EPE_SUM_W-1]) begin
			r = {1'b1, {(EPE_S_W-1){1'b0}}};
		end else begin
			r = {1'b0, {(EPE_S_W-1){1'b1}}};
		end
		return r;
	endfunction

endpackage

>>> src/epe_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial fixed-point multiplier
// Q16.16 by Q32.16 sign-magnitude shift-add, one multiplier bit per cycle,
// rounded half away from zero and saturated to a signed Q32.16 state.
// ----------------------------------------------------------------------------
module epe_mul import epe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mul_req_t req,
	output mul_rsp_t rsp
);

	localparam int StepW = $clog2(EPE_COEF_W);
	localparam int MagW  = EPE_S_W + EPE_COEF_W - EPE_FRAC;

	typedef enum logic [3:0] {
		M_IDLE  = 4'b0001,
		M_RUN   = 4'b0010,
		M_ROUND = 4'b0100,
		M_SAT   = 4'b1000
	} mul_st_t;

	mul_st_t                   st_q;
	logic [StepW-1:0]          cnt_q;
	logic                      done_q;
	logic [EPE_S_W-1:0]        hi_q;
	logic [EPE_COEF_W-1:0]     lo_q;
	logic [EPE_S_W-1:0]        bm_q;
	logic                      neg_q;
	logic [MagW-1:0]           m_q;
	logic signed [EPE_S_W-1:0] p_q;

	logic [EPE_S_W:0]          step_sum;
	logic                      over_pos;
	logic                      over_neg;
	logic signed [EPE_S_W-1:0] p_d;

	assign step_sum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, bm_q} : '0);

	assign over_pos = |m_q[MagW-1:EPE_S_W-1];
	assign over_neg = (|m_q[MagW-1:EPE_S_W]) || (m_q[EPE_S_W-1] && (|m_q[EPE_S_W-2:0]));

	always_comb begin
		if (neg_q) begin
			p_d = over_neg ? {1'b1, {(EPE_S_W-1){1'b0}}} : -$signed(m_q[EPE_S_W-1:0]);
		end else begin
			p_d = over_pos ? {1'b0, {(EPE_S_W-1){1'b1}}} : $signed(m_q[EPE_S_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= M_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				M_IDLE: begin
					cnt_q <= '0;
					if (req.start) st_q <= M_RUN;
				end
				M_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == StepW'(EPE_COEF_W - 1)) st_q <= M_ROUND;
				end
				M_ROUND: st_q <= M_SAT;
				M_SAT: begin
					done_q <= 1'b1;
					st_q   <= M_IDLE;
				end
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			M_IDLE: begin
				if (req.start) begin
					hi_q  <= '0;
					lo_q  <= req.a[EPE_COEF_W-1] ? EPE_COEF_W'(-req.a) : EPE_COEF_W'(req.a);
					bm_q  <= req.b[EPE_S_W-1] ? EPE_S_W'(-req.b) : EPE_S_W'(req.b);
					neg_q <= req.a[EPE_COEF_W-1] ^ req.b[EPE_S_W-1];
				end
			end
			M_RUN: begin
				// add on the low multiplier bit, shift the product down
				hi_q <= step_sum[EPE_S_W:1];
				lo_q <= {step_sum[0], lo_q[EPE_COEF_W-1:1]};
			end
			M_ROUND: m_q <= {hi_q, lo_q[EPE_COEF_W-1:EPE_FRAC]} + MagW'(lo_q[EPE_FRAC-1]);
			M_SAT:   p_q <= p_d;
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.p    = p_q;

endmodule

>>> src/epe_div100.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial divide by the step count
// Restoring division of a signed state by 100, one quotient bit per cycle,
// rounded half away from zero.
// ----------------------------------------------------------------------------
module epe_div100 import epe_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	localparam int StepW = $clog2(EPE_S_W);
	localparam int RemW  = $clog2(EPE_DT_DIV);
	localparam logic [EPE_S_W-1:0] HalfPos = EPE_S_W'(EPE_DT_DIV / 2);
	localparam logic [EPE_S_W-1:0] HalfNeg = EPE_S_W'(EPE_DT_DIV / 2 + 1);

	typedef enum logic [2:0] {
		D_IDLE = 3'b001,
		D_RUN  = 3'b010,
		D_SIGN = 3'b100
	} div_st_t;

	div_st_t                   st_q;
	logic [StepW-1:0]          cnt_q;
	logic                      done_q;
	logic [EPE_S_W-1:0]        n_q;
	logic [RemW-1:0]           rem_q;
	logic                      neg_q;
	logic signed [EPE_S_W-1:0] q_q;

	logic [RemW:0] trial;
	logic          ge;

	assign trial = {rem_q, n_q[EPE_S_W-1]};
	assign ge    = trial >= (RemW+1)'(EPE_DT_DIV);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= D_IDLE;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (st_q)
				D_IDLE: begin
					cnt_q <= '0;
					if (req.start) st_q <= D_RUN;
				end
				D_RUN: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == StepW'(EPE_S_W - 1)) st_q <= D_SIGN;
				end
				D_SIGN: begin
					done_q <= 1'b1;
					st_q   <= D_IDLE;
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			D_IDLE: begin
				if (req.start) begin
					// magnitude plus half the divisor in one add
					n_q   <= req.v[EPE_S_W-1] ? (~req.v) + HalfNeg : req.v + HalfPos;
					neg_q <= req.v[EPE_S_W-1];
					rem_q <= '0;
				end
			end
			D_RUN: begin
				rem_q <= ge ? RemW'(trial - (RemW+1)'(EPE_DT_DIV)) : trial[RemW-1:0];
				n_q   <= {n_q[EPE_S_W-2:0], ge};
			end
			D_SIGN:  q_q <= neg_q ? -$signed(n_q) : $signed(n_q);
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.q    = q_q;

endmodule

>>> src/engine_plant_euler_step_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine plant Euler step core
// One input beat is one 10 ms tick: the core steps a two-state engine speed
// plant and a first-order temperature model with forward Euler in fixed
// point and returns one beat with the rpm and temperature. Each item runs
// seven products on the bit-serial multiplier (32 shift-add steps each) and
// three divisions by 100 on the bit-serial divider (48 quotient steps each),
// one after another, then loads the output register once that is free. A
// finished result waits in the output register while the next tick is
// accepted. Configuration is to be written by the user only while no tick
// is in flight; the core itself does not enforce this.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module engine_plant_euler_step_core import epe_pkg::*; #(
	parameter logic signed [EPE_COEF_W-1:0] ROOM_TEMP       = EPE_ROOM_TEMP,
	parameter logic signed [EPE_COEF_W-1:0] OPERATING_DELTA = EPE_OPERATING_DELTA,
	parameter logic signed [EPE_COEF_W-1:0] REDLINE_DELTA   = EPE_REDLINE_DELTA
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [EPE_CFG_W-1:0]  cfg_index,
	input  logic [EPE_COEF_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  in_beat_t              in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output out_beat_t             out_data
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_ISSUE  = 4'b0010,
		ST_WAIT   = 4'b0100,
		ST_FINISH = 4'b1000
	} st_t;

	typedef enum logic [3:0] {
		OP_A11     = 4'd0,
		OP_A12     = 4'd1,
		OP_B11     = 4'd2,
		OP_DIV1    = 4'd3,
		OP_A21     = 4'd4,
		OP_DIV2    = 4'd5,
		OP_C12     = 4'd6,
		OP_TAU_FB  = 4'd7,
		OP_DIV3    = 4'd8,
		OP_TAU_OUT = 4'd9
	} op_t;

	function automatic op_t next_op(input op_t op);
		op_t r;
		unique case (op)
			OP_A11:    r = OP_A12;
			OP_A12:    r = OP_B11;
			OP_B11:    r = OP_DIV1;
			OP_DIV1:   r = OP_A21;
			OP_A21:    r = OP_DIV2;
			OP_DIV2:   r = OP_C12;
			OP_C12:    r = OP_TAU_FB;
			OP_TAU_FB: r = OP_DIV3;
			OP_DIV3:   r = OP_TAU_OUT;
			default:   r = OP_A11;
		endcase
		return r;
	endfunction

	// configuration
	logic signed [EPE_COEF_W-1:0] a11_q, a12_q, a21_q, b11_q, c12_q;
	logic [EPE_RPM_W-1:0]         idle_q, redline_q, invtau_q;

	// sequencer and model state
	st_t                          state_q;
	op_t                          op_q;
	logic signed [EPE_S_W-1:0]    s1_q, s2_q, ts_q;
	logic [EPE_RPM_W-1:0]         prev_rpm_q;
	logic                         out_valid_q;

	// working registers
	logic                         on_q;
	logic signed [EPE_COEF_W-1:0] u_q;
	logic signed [EPE_TGT_W-1:0]  target_q;
	logic signed [EPE_SUM_W-1:0]  sum_q;
	logic signed [EPE_S_W-1:0]    d_q;
	logic [EPE_RPM_W-1:0]         rpm_q;
	logic signed [EPE_COEF_W-1:0] temp_q;
	out_beat_t                    out_data_q;

	mul_req_t mul_req;
	mul_rsp_t mul_rsp;
	div_req_t div_req;
	div_rsp_t div_rsp;

	logic                         in_take;
	logic                         is_div;
	logic                         unit_done;
	logic                         op_done;
	logic                         out_load;
	logic signed [EPE_S_W-1:0]    p;
	logic signed [EPE_S_W-1:0]    q;
	logic                         raw_le0;
	logic [EPE_RPM_W-1:0]         rpm_d;
	logic signed [EPE_COEF_W-1:0] temp_d;
	logic signed [EPE_COEF_W-1:0] idle_s;
	logic signed [EPE_COEF_W-1:0] u_d;
	logic signed [EPE_TGT_W-1:0]  target_d;

	epe_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.rsp    (mul_rsp)
	);

	epe_div100 u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_take   = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign is_div    = (op_q == OP_DIV1) || (op_q == OP_DIV2) || (op_q == OP_DIV3);
	assign unit_done = is_div ? div_rsp.done : mul_rsp.done;
	assign op_done   = (state_q == ST_WAIT) && unit_done;
	assign out_load  = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);
	assign p         = mul_rsp.p;
	assign q         = div_rsp.q;

	// command and temperature target for the tick being accepted
	assign idle_s = $signed({1'b0, idle_q});
	always_comb begin
		u_d      = '0;
		target_d = {ROOM_TEMP[EPE_COEF_W-1], ROOM_TEMP};
		if (in_data.engine_on) begin
			u_d = (in_data.commanded_rpm > idle_s) ? in_data.commanded_rpm : idle_s;
			if (prev_rpm_q < redline_q) begin
				target_d = target_d + {OPERATING_DELTA[EPE_COEF_W-1], OPERATING_DELTA};
			end else begin
				target_d = target_d + {REDLINE_DELTA[EPE_COEF_W-1], REDLINE_DELTA};
			end
		end
	end

	// operand select for the shared units
	always_comb begin
		mul_req.start = (state_q == ST_ISSUE) && !is_div;
		mul_req.a     = '0;
		mul_req.b     = '0;
		unique case (op_q)
			OP_A11: begin
				mul_req.a = a11_q;
				mul_req.b = s1_q;
			end
			OP_A12: begin
				mul_req.a = a12_q;
				mul_req.b = s2_q;
			end
			OP_B11: begin
				mul_req.a = b11_q;
				mul_req.b = {{(EPE_S_W-EPE_COEF_W){u_q[EPE_COEF_W-1]}}, u_q};
			end
			OP_A21: begin
				mul_req.a = a21_q;
				mul_req.b = s1_q;
			end
			OP_C12: begin
				mul_req.a = c12_q;
				mul_req.b = s2_q;
			end
			OP_TAU_FB, OP_TAU_OUT: begin
				mul_req.a = $signed({1'b0, invtau_q});
				mul_req.b = ts_q;
			end
			default: ;
		endcase
		div_req.start = (state_q == ST_ISSUE) && is_div;
		div_req.v     = d_q;
	end

	// rpm clamp and temperature clamp
	assign raw_le0 = p[EPE_S_W-1] || (p == '0);
	always_comb begin
		if (raw_le0) begin
			rpm_d = '0;
		end else if (|p[EPE_S_W-2:EPE_RPM_W]) begin
			rpm_d = '1;
		end else begin
			rpm_d = p[EPE_RPM_W-1:0];
		end
		if (p[EPE_S_W-1:EPE_COEF_W-1] == '0 || p[EPE_S_W-1:EPE_COEF_W-1] == '1) begin
			temp_d = p[EPE_COEF_W-1:0];
		end else if (p[EPE_S_W-1]) begin
			temp_d = {1'b1, {(EPE_COEF_W-1){1'b0}}};
		end else begin
			temp_d = {1'b0, {(EPE_COEF_W-1){1'b1}}};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a11_q     <= '0;
			a12_q     <= '0;
			a21_q     <= '0;
			b11_q     <= '0;
			c12_q     <= '0;
			idle_q    <= '0;
			redline_q <= '0;
			invtau_q  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_A11:     a11_q     <= cfg_data;
				CFG_A12:     a12_q     <= cfg_data;
				CFG_A21:     a21_q     <= cfg_data;
				CFG_B11:     b11_q     <= cfg_data;
				CFG_C12:     c12_q     <= cfg_data;
				CFG_IDLE:    idle_q    <= cfg_data[EPE_RPM_W-1:0];
				CFG_REDLINE: redline_q <= cfg_data[EPE_RPM_W-1:0];
				CFG_INVTAU:  invtau_q  <= cfg_data[EPE_RPM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_A11;
			s1_q        <= '0;
			s2_q        <= '0;
			ts_q        <= '0;
			prev_rpm_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (op_done) begin
				unique case (op_q)
					OP_DIV1: s1_q <= sat_s(sext_s(s1_q) + sext_s(q));
					OP_DIV2: s2_q <= sat_s(sext_s(s2_q) + sext_s(q));
					OP_DIV3: ts_q <= sat_s(sext_s(ts_q) + sext_s(q));
					OP_C12: begin
						prev_rpm_q <= rpm_d;
						// engine off and no positive speed left: drop both states
						if (!on_q && raw_le0) begin
							s1_q <= '0;
							s2_q <= '0;
						end
					end
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						op_q    <= OP_A11;
						state_q <= ST_ISSUE;
					end
				end
				ST_ISSUE: state_q <= ST_WAIT;
				ST_WAIT: begin
					if (unit_done) begin
						op_q    <= next_op(op_q);
						state_q <= (op_q == OP_TAU_OUT) ? ST_FINISH : ST_ISSUE;
					end
				end
				ST_FINISH: begin
					if (out_load) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			on_q     <= in_data.engine_on;
			u_q      <= u_d;
			target_q <= target_d;
		end
		if (op_done) begin
			unique case (op_q)
				OP_A11:     sum_q  <= sext_s(p);
				OP_A12:     sum_q  <= sum_q + sext_s(p);
				OP_B11:     d_q    <= sat_s(sum_q + sext_s(p));
				OP_A21:     d_q    <= p;
				OP_C12:     rpm_q  <= rpm_d;
				OP_TAU_FB:  d_q    <= sat_s(
					{{(EPE_SUM_W-EPE_TGT_W){target_q[EPE_TGT_W-1]}}, target_q} - sext_s(p));
				OP_TAU_OUT: temp_q <= temp_d;
				default: ;
			endcase
		end
		if (out_load) begin
			out_data_q.engine_rpm         <= rpm_q;
			out_data_q.engine_temperature <= temp_q;
		end
	end

	`ASSERT_NEXT(a_accept_starts_seq, clk, arst_n, in_take, (state_q == ST_ISSUE) && (op_q == OP_A11))
	`ASSERT_NOW(a_done_only_waiting, clk, arst_n, mul_rsp.done || div_rsp.done, state_q == ST_WAIT)
	`ASSERT_NOW(a_units_exclusive, clk, arst_n, mul_rsp.done, !div_rsp.done)

endmodule

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine plant Euler step testbench
// Drives ticks into the core, predicts every rpm and temperature reading with
// its own fixed-point plant model and compares them beat by beat. A scripted
// opening covers field and register extremes, idle floor, redline switching,
// state clearing and saturation; random phases follow, each with a fresh
// register set and one of four patterns of source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_top import epe_pkg::*; ();

	localparam int          PHASES     = 8;
	localparam int          PHASE_TICKS = 235;
	localparam int unsigned LIMIT      = 6000000;
	localparam int          TAIL       = 600;

	localparam longint S48_HI = 64'sd140737488355327;
	localparam longint S48_LO = -64'sd140737488355328;
	localparam longint Q_MAX  = 64'sd2147483647;
	localparam longint Q_MIN  = -64'sd2147483648;

	typedef enum logic [1:0] {ROW_TICK, ROW_KNOWN, ROW_REG} row_kind_t;

	typedef struct packed {
		row_kind_t   kind;
		cfg_idx_t    sel;
		logic [31:0] word;
		logic        on;
		out_beat_t   want;
	} script_row_t;

	localparam out_beat_t QUIET = '0;
	localparam int SCRIPT_LEN = 38;

	localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
		'{ROW_KNOWN, CFG_A11,     32'h7FFF_FFFF, 1'b1, QUIET},
		'{ROW_KNOWN, CFG_A11,     32'h8000_0000, 1'b0, QUIET},
		'{ROW_KNOWN, CFG_A11,     32'h0000_0000, 1'b1, QUIET},
		'{ROW_KNOWN, CFG_A11,     32'hFFFF_FFFF, 1'b0, QUIET},
		'{ROW_REG,   CFG_A11,     32'h8000_0000, 1'b0, QUIET},
		'{ROW_REG,   CFG_A12,     32'hFFFF_0000, 1'b0, QUIET},
		'{ROW_REG,   CFG_A21,     32'h7FFF_FFFF, 1'b0, QUIET},
		'{ROW_REG,   CFG_B11,     32'h7FFF_FFFF, 1'b0, QUIET},
		'{ROW_REG,   CFG_C12,     32'h7FFF_FFFF, 1'b0, QUIET},
		'{ROW_REG,   CFG_IDLE,    32'h7FFF_FFFF, 1'b0, QUIET},
		'{ROW_REG,   CFG_REDLINE, 32'h0000_0000, 1'b0, QUIET},
		// command below the idle floor, then rpm into saturation
		'{ROW_TICK,  CFG_A11,     32'h8000_0000, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h7FFF_FFFF, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h0000_0001, 1'b1, QUIET},
		// negative output gain: clamp while running, clear once off
		'{ROW_REG,   CFG_C12,     32'h8000_0000, 1'b0, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h0000_0000, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h7FFF_FFFF, 1'b0, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h8000_0000, 1'b0, QUIET},
		// top bit of an unsigned register must be dropped
		'{ROW_REG,   CFG_INVTAU,  32'h7FFF_FFFF, 1'b0, QUIET},
		'{ROW_REG,   CFG_REDLINE, 32'hFFFF_FFFF, 1'b0, QUIET},
		'{ROW_REG,   CFG_IDLE,    32'h0000_0000, 1'b0, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h0001_0000, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h8000_0000, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h7FFF_FFFF, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h0000_0000, 1'b0, QUIET},
		'{ROW_REG,   CFG_C12,     32'h0001_0000, 1'b0, QUIET},
		'{ROW_REG,   CFG_A11,     32'hFFFF_0000, 1'b0, QUIET},
		'{ROW_REG,   CFG_A12,     32'h0000_0000, 1'b0, QUIET},
		'{ROW_REG,   CFG_A21,     32'h0000_8000, 1'b0, QUIET},
		'{ROW_REG,   CFG_B11,     32'h0001_0000, 1'b0, QUIET},
		'{ROW_REG,   CFG_INVTAU,  32'h0000_0100, 1'b0, QUIET},
		'{ROW_REG,   CFG_REDLINE, 32'h0010_0000, 1'b0, QUIET},
		// rpm climbs past a low redline, temperature target follows
		'{ROW_TICK,  CFG_A11,     32'h0064_0000, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h0064_0000, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h0064_0000, 1'b1, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h0064_0000, 1'b0, QUIET},
		'{ROW_TICK,  CFG_A11,     32'hFFF0_0000, 1'b0, QUIET},
		'{ROW_TICK,  CFG_A11,     32'h7FFF_FFFF, 1'b1, QUIET}
	};

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [EPE_CFG_W-1:0]  cfg_index;
	logic [EPE_COEF_W-1:0] cfg_data;
	logic                  in_valid;
	logic                  in_stall;
	in_beat_t              in_data;
	logic                  out_valid;
	logic                  out_stall;
	out_beat_t             out_data;

	// register copies
	longint k_a11, k_a12, k_a21, k_b11, k_c12, k_idle, k_redline, k_invtau;
	// plant, temperature and rpm history
	longint x_speed1, x_speed2, x_heat, last_rpm;

	out_beat_t   due_readings[$];
	int          faults;
	int          gap_pct;
	int          stall_pct;
	int unsigned cycle_count;

	engine_plant_euler_step_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic longint clip48(longint v);
		if (v > S48_HI) return S48_HI;
		if (v < S48_LO) return S48_LO;
		return v;
	endfunction

	function automatic longint unsigned magnitude(longint v);
		return (v < 0) ? longint'(-v) : longint'(v);
	endfunction

	function automatic longint signed_of(bit neg, longint unsigned m);
		if (neg) begin
			if (m > 64'd140737488355328) return S48_LO;
			return -longint'(m);
		end
		if (m > 64'd140737488355327) return S48_HI;
		return longint'(m);
	endfunction

	// Q16.16 times Q32.16, rounded half away from zero, saturated to 48 bits
	function automatic longint qmul(longint a, longint b);
		longint unsigned am, bm, m;
		am = magnitude(a);
		bm = magnitude(b);
		m = am * (bm >> 16) + ((am * (bm & 64'hFFFF) + 64'h8000) >> 16);
		return signed_of((a < 0) != (b < 0), m);
	endfunction

	// scale by dt = 1/100 s
	function automatic longint euler_dt(longint v);
		return signed_of(v < 0, (magnitude(v) + 64'd50) / 64'd100);
	endfunction

	function automatic out_beat_t advance_plant(in_beat_t b);
		longint    cmd, u, goal, d, raw, t;
		out_beat_t r;
		cmd = longint'($signed(b.commanded_rpm));
		u = 0;
		goal = longint'(EPE_ROOM_TEMP);
		if (b.engine_on) begin
			u = (cmd > k_idle) ? cmd : k_idle;
			goal += (last_rpm < k_redline) ? longint'(EPE_OPERATING_DELTA)
			                               : longint'(EPE_REDLINE_DELTA);
		end
		d = clip48(qmul(k_a11, x_speed1) + qmul(k_a12, x_speed2) + qmul(k_b11, u));
		x_speed1 = clip48(x_speed1 + euler_dt(d));
		// second state sees the first state of this tick
		d = qmul(k_a21, x_speed1);
		x_speed2 = clip48(x_speed2 + euler_dt(d));
		raw = qmul(k_c12, x_speed2);
		if (!b.engine_on && raw <= 0) begin
			x_speed1 = 0;
			x_speed2 = 0;
		end
		if (raw <= 0) begin
			last_rpm = 0;
		end else if (raw > Q_MAX) begin
			last_rpm = Q_MAX;
		end else begin
			last_rpm = raw;
		end
		d = clip48(goal - qmul(k_invtau, x_heat));
		x_heat = clip48(x_heat + euler_dt(d));
		t = qmul(k_invtau, x_heat);
		if (t > Q_MAX) t = Q_MAX;
		if (t < Q_MIN) t = Q_MIN;
		r.engine_rpm = last_rpm[30:0];
		r.engine_temperature = t[31:0];
		return r;
	endfunction

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(0, 4))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h0000_0000;
			3: return 32'hFFFF_FFFF;
			default: return 32'h0001_0000;
		endcase
	endfunction

	// signed Q16.16 within +/- whole
	function automatic logic [31:0] rand_q(int unsigned whole);
		longint v;
		v = longint'($urandom_range(0, whole * 65536));
		if ($urandom_range(0, 1)) v = -v;
		return v[31:0];
	endfunction

	task automatic note_fault(string what, longint want, longint got);
		faults++;
		if (faults <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $time, what, want, got);
	endtask

	// leaves the write enable high; the caller lowers it after the last write
	task automatic write_reg(cfg_idx_t sel, logic [31:0] v);
		cfg_we <= 1'b1;
		cfg_index <= sel;
		cfg_data <= v;
		case (sel)
			CFG_A11:     k_a11 = longint'($signed(v));
			CFG_A12:     k_a12 = longint'($signed(v));
			CFG_A21:     k_a21 = longint'($signed(v));
			CFG_B11:     k_b11 = longint'($signed(v));
			CFG_C12:     k_c12 = longint'($signed(v));
			CFG_IDLE:    k_idle = longint'({1'b0, v[30:0]});
			CFG_REDLINE: k_redline = longint'({1'b0, v[30:0]});
			CFG_INVTAU:  k_invtau = longint'({1'b0, v[30:0]});
		endcase
		@(posedge clk);
	endtask

	// returns in the time step of the accepting edge, valid still high
	task automatic send_tick(in_beat_t b, bit known, out_beat_t want);
		out_beat_t guess;
		while ($urandom_range(0, 99) < gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= b;
		do @(posedge clk); while (in_stall);
		guess = advance_plant(b);
		due_readings.push_back(known ? want : guess);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (due_readings.size() != 0) @(posedge clk);
	endtask

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_readings.size() == 0) begin
				note_fault("unrequested reading", 0, longint'(out_data));
			end else begin
				want = due_readings.pop_front();
				if (out_data.engine_rpm !== want.engine_rpm)
					note_fault("engine_rpm", want.engine_rpm, out_data.engine_rpm);
				if (out_data.engine_temperature !== want.engine_temperature)
					note_fault("engine_temperature", want.engine_temperature,
						out_data.engine_temperature);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		in_beat_t    b;
		logic [31:0] regs [8];
		logic [31:0] v;
		bit          running;
		int          style;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_A11;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		faults = 0;
		gap_pct = 0;
		stall_pct = 0;
		cycle_count = 0;
		k_a11 = 0; k_a12 = 0; k_a21 = 0; k_b11 = 0; k_c12 = 0;
		k_idle = 0; k_redline = 0; k_invtau = 0;
		x_speed1 = 0; x_speed2 = 0; x_heat = 0; last_rpm = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_REG) begin
				drain();
				write_reg(SCRIPT[i].sel, SCRIPT[i].word);
			end else begin
				if (cfg_we) cfg_we <= 1'b0;
				b.commanded_rpm = SCRIPT[i].word;
				b.engine_on = SCRIPT[i].on;
				send_tick(b, SCRIPT[i].kind == ROW_KNOWN, SCRIPT[i].want);
			end
		end

		running = 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			case (ph % 4)
				0: begin gap_pct = 0;  stall_pct = 0;  end
				1: begin gap_pct = 82; stall_pct = 0;  end
				2: begin gap_pct = 0;  stall_pct = 82; end
				default: begin gap_pct = 18; stall_pct = 18; end
			endcase
			style = (ph == 2) ? 1 : ((ph == 5 || ph == 7) ? 2 : 0);
			if (style == 1) begin
				foreach (regs[r]) regs[r] = $urandom;
			end else if (style == 2) begin
				foreach (regs[r]) regs[r] = pick_extreme();
			end else begin
				// damped, plausible engine: keeps the states off the rails
				regs[CFG_A11] = -($urandom_range(0, 40 * 65536));
				regs[CFG_A12] = rand_q(4);
				regs[CFG_A21] = ($urandom_range(0, 4) == 0) ? rand_q(20)
				                                            : $urandom_range(0, 20 * 65536);
				regs[CFG_B11] = $urandom_range(0, 20 * 65536);
				regs[CFG_C12] = ($urandom_range(0, 4) == 0) ? rand_q(4)
				                                            : $urandom_range(0, 4 * 65536);
				regs[CFG_IDLE] = $urandom_range(0, 1500 * 65536);
				regs[CFG_REDLINE] = $urandom_range(1000 * 65536, 7000 * 65536);
				regs[CFG_INVTAU] = ($urandom_range(0, 4) == 0) ? 32'd0
				                                               : $urandom_range(1, 4 * 65536);
				for (int r = CFG_IDLE; r <= CFG_INVTAU; r++)
					regs[r][31] = 1'($urandom_range(0, 1));
			end
			for (int r = 0; r < 8; r++) write_reg(cfg_idx_t'(r), regs[r]);
			cfg_we <= 1'b0;

			for (int n = 0; n < PHASE_TICKS; n++) begin
				// hold engine state in long runs so the plant settles and clears
				if ($urandom_range(0, 24) == 0) running = !running;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: v = $urandom_range(0, 8000 * 65536);
					7: v = -($urandom_range(0, 1 << 24));
					8: v = $urandom;
					default: v = pick_extreme();
				endcase
				b.commanded_rpm = v;
				b.engine_on = running;
				send_tick(b, 1'b0, QUIET);
			end
		end

		drain();
		repeat (TAIL) @(posedge clk);
		if (faults == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
